[hw/rtl/bsm_pkg.sv]
// shared types and constants for the bank switch mapper
`default_nettype none
package bsm_pkg;

	localparam int AddrW   = 16;
	localparam int DataW   = 8;
	localparam int CyclesW = 10;
	localparam int CountW  = 16;
	localparam int CmdW    = 4;
	localparam int CfgIdxW = 2;
	localparam int CfgDataW = 9;

	localparam logic [CountW-1:0]  CountReload    = 16'hFFFF;
	localparam logic [CyclesW-1:0] ScanlineCycles = 10'd114;
	localparam logic [DataW-1:0]   RamSelectBit   = 8'h40;
	localparam logic [1:0]         MirrorMask     = 2'h3;

	typedef enum logic [1:0] {
		KIND_WRITE    = 2'd0,
		KIND_CLOCK    = 2'd1,
		KIND_SCANLINE = 2'd2,
		KIND_NONE     = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		TGT_NONE   = 3'd0,
		TGT_CHR    = 3'd1,
		TGT_PRG    = 3'd2,
		TGT_MIRROR = 3'd3,
		TGT_AUDIO  = 3'd4
	} target_t;

	// top three address bits of a region
	localparam logic [2:0] RegionCmd   = 3'b100;
	localparam logic [2:0] RegionParam = 3'b101;
	localparam logic [2:0] RegionSel   = 3'b110;
	localparam logic [2:0] RegionAudio = 3'b111;

	localparam logic [CmdW-1:0] CmdPrg6000  = 4'h8;
	localparam logic [CmdW-1:0] CmdPrg8000  = 4'h9;
	localparam logic [CmdW-1:0] CmdPrgA000  = 4'hA;
	localparam logic [CmdW-1:0] CmdPrgC000  = 4'hB;
	localparam logic [CmdW-1:0] CmdMirror   = 4'hC;
	localparam logic [CmdW-1:0] CmdIrqEn    = 4'hD;
	localparam logic [CmdW-1:0] CmdCountLo  = 4'hE;
	localparam logic [CmdW-1:0] CmdCountHi  = 4'hF;

	localparam logic [CfgIdxW-1:0] CfgPatchMode = 2'd0;
	localparam logic [CfgIdxW-1:0] CfgIrqSource = 2'd1;
	localparam logic [CfgIdxW-1:0] CfgBankCount = 2'd2;
	localparam logic [CfgIdxW-1:0] CfgHasChrRom = 2'd3;

	typedef struct packed {
		logic               en_write;
		logic               en_value;
		logic               lo_load;
		logic               hi_load;
		logic               clear_pending;
		logic               tick;
		logic [CyclesW-1:0] amount;
		logic [DataW-1:0]   data;
	} irq_ctl_t;

endpackage
`default_nettype wire

[hw/rtl/bsm_irq_timer.sv]
// down-counting interrupt timer with enable, reload and pending flag
`default_nettype none
module bsm_irq_timer
	import bsm_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire irq_ctl_t ctl,
	output logic          pending_next
);

	logic              enabled_q, enabled_d;
	logic              pending_q;
	logic [CountW-1:0] count_q, count_d;

	always_comb begin
		enabled_d    = enabled_q;
		count_d      = count_q;
		pending_next = pending_q;
		if (ctl.clear_pending) begin
			pending_next = 1'b0;
		end
		if (ctl.en_write) begin
			enabled_d = ctl.en_value;
		end
		if (ctl.lo_load) begin
			count_d = {count_q[CountW-1:DataW], ctl.data};
		end
		if (ctl.hi_load) begin
			count_d = {ctl.data, count_q[DataW-1:0]};
		end
		if (ctl.tick && enabled_q) begin
			if (count_q <= {{(CountW-CyclesW){1'b0}}, ctl.amount}) begin
				pending_next = 1'b1;
				enabled_d    = 1'b0;
				count_d      = CountReload;
			end else begin
				count_d = count_q - {{(CountW-CyclesW){1'b0}}, ctl.amount};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= 1'b0;
			pending_q <= 1'b0;
			count_q   <= '0;
		end else begin
			enabled_q <= enabled_d;
			pending_q <= pending_next;
			count_q   <= count_d;
		end
	end

endmodule
`default_nettype wire

[hw/rtl/bank_switch_mapper_with_irq_counter.sv]
// top level: bus write decode, command latch, irq timer and result register
// result: an accepted item's result is registered and shown at the outputs in the next cycle
// throughput: one item per cycle; the result register stalls input only when
// it holds a result that the output side is stalling
// reset: arst_n clears command, timer, config and the result valid
`default_nettype none
module bank_switch_mapper_with_irq_counter
	import bsm_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [1:0]          kind,
	input  wire logic [AddrW-1:0]    addr,
	input  wire logic [DataW-1:0]    data,
	input  wire logic [CyclesW-1:0]  cycles,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic                     irq_line,
	output logic [2:0]               update_target,
	output logic [2:0]               update_slot,
	output logic [DataW-1:0]         update_value,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [CfgIdxW-1:0]  cfg_index,
	input  wire logic [CfgDataW-1:0] cfg_data
);

	logic            patch_mode_q;
	logic            irq_source_q;
	logic [CmdW-1:0] command_q;

	logic            accept;
	logic            out_valid_q;
	logic            irq_line_q;
	target_t         target_q, target_d;
	logic [2:0]      slot_q, slot_d;
	logic [DataW-1:0] value_q, value_d;
	logic            cmd_write;
	irq_ctl_t        ctl;
	logic            pending_next;
	kind_t           kind_in;
	logic [2:0]      region;

	assign cfg_ready = 1'b1;
	assign in_stall  = out_valid_q & out_stall;
	assign accept    = in_valid & ~in_stall;
	assign kind_in   = kind_t'(kind);
	assign region    = addr[AddrW-1:AddrW-3];

	always_comb begin
		target_d     = TGT_NONE;
		slot_d       = '0;
		value_d      = '0;
		cmd_write    = 1'b0;
		ctl          = '0;
		ctl.data     = data;
		if (accept) begin
			unique case (kind_in)
				KIND_WRITE: begin
					unique case (region)
						RegionCmd: cmd_write = 1'b1;
						RegionParam: begin
							case (command_q)
								CmdPrg6000: begin
									if (!patch_mode_q && (data & RamSelectBit) == '0) begin
										target_d = TGT_PRG;
										value_d  = data;
									end
								end
								CmdPrg8000, CmdPrgA000, CmdPrgC000: begin
									target_d = TGT_PRG;
									slot_d   = {1'b0, command_q[1:0]};
									value_d  = data;
								end
								CmdMirror: begin
									target_d     = TGT_MIRROR;
									value_d      = {6'd0, data[1:0] & MirrorMask};
								end
								CmdIrqEn: begin
									ctl.en_write      = 1'b1;
									ctl.en_value      = data != '0;
									ctl.clear_pending = 1'b1;
								end
								CmdCountLo: begin
									ctl.lo_load       = 1'b1;
									ctl.clear_pending = 1'b1;
								end
								CmdCountHi: begin
									ctl.hi_load       = 1'b1;
									ctl.clear_pending = 1'b1;
								end
								default: begin
									target_d = TGT_CHR;
									slot_d   = command_q[2:0];
									value_d  = data;
								end
							endcase
						end
						RegionSel, RegionAudio: begin
							target_d = TGT_AUDIO;
							slot_d   = {2'd0, region[0]};
							value_d  = data;
						end
						default: ;
					endcase
				end
				KIND_CLOCK: begin
					ctl.tick   = ~irq_source_q;
					ctl.amount = cycles;
				end
				KIND_SCANLINE: begin
					ctl.tick   = irq_source_q;
					ctl.amount = ScanlineCycles;
				end
				default: ;
			endcase
		end
	end

	bsm_irq_timer u_timer (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.pending_next (pending_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			patch_mode_q <= 1'b0;
			irq_source_q <= 1'b0;
			command_q    <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					CfgPatchMode: patch_mode_q <= cfg_data[0];
					CfgIrqSource: irq_source_q <= cfg_data[0];
					// bank count and graphics preset are not stored by this block
					default: ;
				endcase
			end
			if (cmd_write) begin
				command_q <= data[CmdW-1:0];
			end
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			irq_line_q <= pending_next;
			target_q   <= target_d;
			slot_q     <= slot_d;
			value_q    <= value_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign irq_line      = irq_line_q;
	assign update_target = target_q;
	assign update_slot   = slot_q;
	assign update_value  = value_q;

endmodule
`default_nettype wire

[tb/bank_switch_mapper_with_irq_counter_tb.sv]
// testbench for the bank switch mapper: random and directed bus traffic checked against a predictor
`default_nettype none
module bank_switch_mapper_with_irq_counter_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import bsm_pkg::*;

	localparam int unsigned CycleLimit  = 200000;
	localparam int unsigned HoldCycles  = 300;
	localparam int unsigned DrainCycles = 4;

	typedef struct packed {
		kind_t              kind;
		logic [AddrW-1:0]   addr;
		logic [DataW-1:0]   data;
		logic [CyclesW-1:0] cycles;
	} bus_item_t;

	typedef struct packed {
		logic             irq;
		target_t          target;
		logic [2:0]       slot;
		logic [DataW-1:0] value;
	} mapper_update_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	kind_t               kind = KIND_NONE;
	logic [AddrW-1:0]    addr = '0;
	logic [DataW-1:0]    data = '0;
	logic [CyclesW-1:0]  cycles = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic                irq_line;
	logic [2:0]          update_target;
	logic [2:0]          update_slot;
	logic [DataW-1:0]    update_value;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [CfgIdxW-1:0]  cfg_index = '0;
	logic [CfgDataW-1:0] cfg_data = '0;

	bus_item_t      bus_items[$];
	mapper_update_t expected_updates[$];
	bus_item_t      cur_item;
	int unsigned    send_idle_pct = 0;
	int unsigned    recv_stall_pct = 0;
	logic           hold_armed = 1'b0;
	int unsigned    hold_count = 0;
	int unsigned    cycle_count = 0;
	int unsigned    mismatches = 0;

	// predictor copy of configuration and mapper state
	logic                patch_mode_q = 1'b0;
	logic                irq_source_q = 1'b0;
	logic [CfgDataW-1:0] bank_count_q = 9'd32;
	logic                chr_rom_q = 1'b1;
	logic [CmdW-1:0]     cmd_latch;
	logic [DataW-1:0]    chr_banks[8];
	logic [DataW-1:0]    prg_banks[4];
	logic [1:0]          mirror_mode;
	logic                timer_en;
	logic [CountW-1:0]   timer_count;
	logic                timer_pend;

	bank_switch_mapper_with_irq_counter i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.kind          (kind),
		.addr          (addr),
		.data          (data),
		.cycles        (cycles),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.irq_line      (irq_line),
		.update_target (update_target),
		.update_slot   (update_slot),
		.update_value  (update_value),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic reset_mapper_model();
		cmd_latch = '0;
		for (int i = 0; i < 8; i++)
			chr_banks[i] = chr_rom_q ? DataW'(i) : '0;
		prg_banks[0] = '0;
		prg_banks[1] = '0;
		prg_banks[2] = 8'd1;
		prg_banks[3] = DataW'(bank_count_q - 9'd2);
		mirror_mode = '0;
		timer_en = 1'b0;
		timer_count = '0;
		timer_pend = 1'b0;
	endtask

	function automatic mapper_update_t predict_mapper(bus_item_t it);
		mapper_update_t u;
		logic [2:0] region;
		logic [CountW-1:0] amount;
		logic tick;
		u.irq = 1'b0;
		u.target = TGT_NONE;
		u.slot = '0;
		u.value = '0;
		region = it.addr[15:13];
		amount = '0;
		tick = 1'b0;
		if (it.kind == KIND_WRITE) begin
			if (region == RegionCmd) begin
				cmd_latch = it.data[CmdW-1:0];
			end else if (region == RegionParam) begin
				if (cmd_latch < CmdPrg6000) begin
					chr_banks[cmd_latch[2:0]] = it.data;
					u.target = TGT_CHR;
					u.slot = cmd_latch[2:0];
					u.value = it.data;
				end else if (cmd_latch == CmdPrg6000) begin
					if (!patch_mode_q && (it.data & RamSelectBit) == '0) begin
						prg_banks[0] = it.data;
						u.target = TGT_PRG;
						u.value = it.data;
					end
				end else if (cmd_latch <= CmdPrgC000) begin
					prg_banks[2'(cmd_latch - CmdPrg6000)] = it.data;
					u.target = TGT_PRG;
					u.slot = 3'(cmd_latch - CmdPrg6000);
					u.value = it.data;
				end else if (cmd_latch == CmdMirror) begin
					mirror_mode = it.data[1:0] & MirrorMask;
					u.target = TGT_MIRROR;
					u.value = DataW'(mirror_mode);
				end else if (cmd_latch == CmdIrqEn) begin
					timer_en = (it.data != '0);
					timer_pend = 1'b0;
				end else if (cmd_latch == CmdCountLo) begin
					timer_count[7:0] = it.data;
					timer_pend = 1'b0;
				end else begin
					timer_count[15:8] = it.data;
					timer_pend = 1'b0;
				end
			end else if (region == RegionSel || region == RegionAudio) begin
				u.target = TGT_AUDIO;
				u.slot = (region == RegionAudio) ? 3'd1 : 3'd0;
				u.value = it.data;
			end
		end else if (it.kind == KIND_CLOCK) begin
			tick = !irq_source_q;
			amount = CountW'(it.cycles);
		end else if (it.kind == KIND_SCANLINE) begin
			tick = irq_source_q;
			amount = CountW'(ScanlineCycles);
		end
		if (tick && timer_en) begin
			if (timer_count <= amount) begin
				timer_pend = 1'b1;
				timer_en = 1'b0;
				timer_count = CountReload;
			end else begin
				timer_count = timer_count - amount;
			end
		end
		u.irq = timer_pend;
		return u;
	endfunction

	// sender
	always @(posedge clk) begin
		bus_item_t nxt;
		if (in_valid && !in_stall)
			expected_updates.push_back(predict_mapper(cur_item));
		if (!in_valid || !in_stall) begin
			if (bus_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				nxt = bus_items.pop_front();
				cur_item = nxt;
				in_valid <= 1'b1;
				kind <= nxt.kind;
				addr <= nxt.addr;
				data <= nxt.data;
				cycles <= nxt.cycles;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver stall, with one long hold-off when armed
	always @(posedge clk) begin
		if (hold_armed && hold_count < HoldCycles) begin
			out_stall <= 1'b1;
			hold_count++;
		end else begin
			out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	// result checker
	always @(posedge clk) begin
		mapper_update_t got;
		mapper_update_t want;
		if (out_valid && !out_stall) begin
			got = '{irq_line, target_t'(update_target), update_slot, update_value};
			if (expected_updates.size() == 0) begin
				$display("%0t unexpected transaction irq %0d target %0d slot %0d value %0h",
					$time, got.irq, got.target, got.slot, got.value);
				mismatches++;
			end else begin
				want = expected_updates.pop_front();
				if (got !== want) begin
					$display("%0t mismatch expected irq %0d target %0d slot %0d value %0h",
						$time, want.irq, want.target, want.slot, want.value);
					$display("%0t          actual   irq %0d target %0d slot %0d value %0h",
						$time, got.irq, got.target, got.slot, got.value);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic push_item(kind_t k, logic [AddrW-1:0] a, logic [DataW-1:0] d,
		logic [CyclesW-1:0] c);
		bus_items.push_back('{k, a, d, c});
	endtask

	task automatic push_write(logic [AddrW-1:0] a, logic [DataW-1:0] d);
		push_item(KIND_WRITE, a, d, '0);
	endtask

	task automatic push_counter_arm(logic [DataW-1:0] lo, logic [DataW-1:0] hi,
		logic [DataW-1:0] en);
		push_write({RegionCmd, 13'($urandom)}, {4'($urandom), CmdCountLo});
		push_write({RegionParam, 13'($urandom)}, lo);
		push_write({RegionCmd, 13'($urandom)}, {4'($urandom), CmdCountHi});
		push_write({RegionParam, 13'($urandom)}, hi);
		push_write({RegionCmd, 13'($urandom)}, {4'($urandom), CmdIrqEn});
		push_write({RegionParam, 13'($urandom)}, en);
	endtask

	task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			CfgPatchMode: patch_mode_q = val[0];
			CfgIrqSource: irq_source_q = val[0];
			CfgBankCount: bank_count_q = val;
			CfgHasChrRom: chr_rom_q = val[0];
			default: ;
		endcase
	endtask

	task automatic wait_drained();
		do
			@(posedge clk);
		while (bus_items.size() != 0 || in_valid || expected_updates.size() != 0);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic queue_random_traffic(int unsigned n);
		int unsigned queued;
		int unsigned pick;
		int unsigned ticks;
		logic [CmdW-1:0] cmd;
		logic [DataW-1:0] val;
		queued = 0;
		while (queued < n) begin
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				cmd = CmdW'($urandom);
				val = DataW'($urandom);
				if (cmd == CmdPrg6000 && $urandom_range(0, 1) == 1)
					val[6] = 1'b0;
				push_write({RegionCmd, 13'($urandom)}, {4'($urandom), cmd});
				push_write({RegionParam, 13'($urandom)}, val);
				queued += 2;
			end else if (pick < 55) begin
				push_write({2'b11, 14'($urandom)}, DataW'($urandom));
				queued++;
			end else if (pick < 75) begin
				ticks = $urandom_range(1, 8);
				push_counter_arm(DataW'($urandom), DataW'($urandom_range(0, 3)),
					DataW'($urandom_range(1, 255)));
				repeat (ticks)
					push_item(kind_t'($urandom_range(1, 2)), AddrW'($urandom),
						DataW'($urandom), CyclesW'($urandom));
				queued += 6 + ticks;
			end else if (pick < 90) begin
				push_item(kind_t'($urandom_range(1, 2)), AddrW'($urandom),
					DataW'($urandom), CyclesW'($urandom));
				queued++;
			end else begin
				// noise, mostly ignored by the block
				push_item(kind_t'($urandom_range(0, 3)), AddrW'($urandom),
					DataW'($urandom), CyclesW'($urandom));
				queued++;
			end
		end
	endtask

	initial begin
		reset_mapper_model();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		cfg_write(CfgPatchMode, 9'd0);
		cfg_write(CfgIrqSource, 9'd0);
		cfg_write(CfgBankCount, 9'd2);
		cfg_write(CfgHasChrRom, 9'd0);

		// directed: ignored writes, CHR, PRG, mirror and timer commands, audio, timer firing
		push_write(16'h0000, 8'hFF);
		push_write(16'h7FFF, 8'h00);
		push_write(16'h8000, 8'h00);
		push_write(16'hA000, 8'hFF);
		push_write(16'h9FFF, 8'hF7);
		push_write(16'hBFFF, 8'h00);
		push_write(16'h8000, {4'h0, CmdPrg6000});
		push_write(16'hA000, 8'h3F);
		push_write(16'hA001, 8'hC0);
		push_write(16'h8000, {4'h0, CmdPrg8000});
		push_write(16'hA000, 8'h80);
		push_write(16'h8000, {4'h0, CmdPrgC000});
		push_write(16'hA000, 8'hFE);
		push_write(16'h8000, {4'h0, CmdMirror});
		push_write(16'hA000, 8'hFF);
		push_write(16'hC000, 8'h55);
		push_write(16'hFFFF, 8'hAA);
		push_counter_arm(8'h00, 8'h00, 8'h80);
		push_item(KIND_CLOCK, '0, '0, '0);
		push_item(KIND_NONE, 16'hFFFF, 8'hFF, 10'h3FF);
		push_write(16'h8000, {4'h0, CmdIrqEn});
		push_write(16'hA000, 8'h00);
		wait_drained();

		cfg_write(CfgPatchMode, 9'd1);
		cfg_write(CfgIrqSource, 9'd1);
		cfg_write(CfgBankCount, 9'd256);
		cfg_write(CfgHasChrRom, 9'd1);
		// scanline decrement equal to the count fires
		push_counter_arm(8'h72, 8'h00, 8'h01);
		push_item(KIND_SCANLINE, '0, '0, '0);
		push_write(16'h8000, {4'h0, CmdPrg6000});
		push_write(16'hA000, 8'h00);
		send_idle_pct = 51;
		queue_random_traffic(100);
		wait_drained();

		cfg_write(CfgPatchMode, 9'd0);
		send_idle_pct = 0;
		recv_stall_pct = 51;
		queue_random_traffic(100);
		wait_drained();

		cfg_write(CfgIrqSource, 9'd0);
		cfg_write(CfgBankCount, 9'd32);
		send_idle_pct = 24;
		recv_stall_pct = 24;
		queue_random_traffic(100);
		wait_drained();

		cfg_write(CfgPatchMode, 9'd1);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		queue_random_traffic(60);
		hold_armed = 1'b1;
		wait_drained();

		cfg_write(CfgPatchMode, 9'd0);
		cfg_write(CfgIrqSource, 9'd1);
		queue_random_traffic(40);
		wait_drained();

		if (mismatches == 0 && expected_updates.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
`default_nettype wire
